>>> design/gtrd_pkg.sv
// Shared types, constants and helper functions of the glyph to rectangle decomposer.
package gtrd_pkg;

    localparam int COORD_BITS    = 12;
    localparam int GLYPH_BITS    = 5;
    localparam int CFG_BITS      = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int SIZE_BITS     = 9;
    localparam int REL_BITS      = 11;
    localparam int MAX_RECTS     = 7;
    localparam int RECT_IDX_BITS = 3;
    localparam int SUM_BITS      = ((COORD_BITS > REL_BITS) ? COORD_BITS : REL_BITS) + 1;

    localparam int S_DATA_BITS  = ((2 * COORD_BITS + GLYPH_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 * COORD_BITS + 2 * SIZE_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FONT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FONT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FONT_WEIGHT = 2'd2;

    localparam logic [CFG_BITS-1:0] FONT_WIDTH_RST  = 8'd16;
    localparam logic [CFG_BITS-1:0] FONT_HEIGHT_RST = 8'd28;
    localparam logic [CFG_BITS-1:0] FONT_WEIGHT_RST = 8'd4;

    // Glyph codes
    localparam logic [GLYPH_BITS-1:0] GLYPH_D0 = 5'd0;
    localparam logic [GLYPH_BITS-1:0] GLYPH_D1 = 5'd1;
    localparam logic [GLYPH_BITS-1:0] GLYPH_D2 = 5'd2;
    localparam logic [GLYPH_BITS-1:0] GLYPH_D3 = 5'd3;
    localparam logic [GLYPH_BITS-1:0] GLYPH_D4 = 5'd4;
    localparam logic [GLYPH_BITS-1:0] GLYPH_D5 = 5'd5;
    localparam logic [GLYPH_BITS-1:0] GLYPH_D6 = 5'd6;
    localparam logic [GLYPH_BITS-1:0] GLYPH_D7 = 5'd7;
    localparam logic [GLYPH_BITS-1:0] GLYPH_D8 = 5'd8;
    localparam logic [GLYPH_BITS-1:0] GLYPH_D9 = 5'd9;
    localparam logic [GLYPH_BITS-1:0] GLYPH_A  = 5'd10;
    localparam logic [GLYPH_BITS-1:0] GLYPH_F  = 5'd11;
    localparam logic [GLYPH_BITS-1:0] GLYPH_G  = 5'd12;
    localparam logic [GLYPH_BITS-1:0] GLYPH_N  = 5'd13;
    localparam logic [GLYPH_BITS-1:0] GLYPH_O  = 5'd14;
    localparam logic [GLYPH_BITS-1:0] GLYPH_P  = 5'd15;
    localparam logic [GLYPH_BITS-1:0] GLYPH_R  = 5'd16;
    localparam logic [GLYPH_BITS-1:0] GLYPH_S  = 5'd17;
    localparam logic [GLYPH_BITS-1:0] GLYPH_T  = 5'd18;

    // Reciprocal multipliers for division by 7, 10 and 5/4 of an 8-bit value
    localparam int RECIP7_BITS  = 9;
    localparam int RECIP7       = 293;
    localparam int SHIFT7       = 11;
    localparam int RECIP10_BITS = 8;
    localparam int RECIP10      = 205;
    localparam int SHIFT10      = 11;
    localparam int RECIPN_BITS  = 12;
    localparam int RECIPN       = 3277;
    localparam int SHIFTN       = 12;

    typedef logic signed [REL_BITS-1:0]   rel_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [SIZE_BITS-1:0]         size_t;
    typedef logic [GLYPH_BITS-1:0]        glyph_t;
    typedef logic [RECT_IDX_BITS-1:0]     rect_idx_t;

    localparam logic signed [SUM_BITS-1:0] COORD_HI = SUM_BITS'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] COORD_LO = -COORD_HI - SUM_BITS'(1);
    localparam rel_t SIZE_LIMIT = rel_t'((1 << SIZE_BITS) - 1);

    // Cell geometry derived from the font registers
    typedef struct packed {
        rel_t fw;
        rel_t fh;
        rel_t wt;
        rel_t h2;
        rel_t w2;
        rel_t w7;
        rel_t d;
        rel_t n;
        rel_t bar;
        rel_t qr;
        rel_t tx;
        rel_t w15a;
        rel_t w15b;
    } geom_t;

    typedef struct packed {
        rel_t dx;
        rel_t dy;
        rel_t h;
        rel_t wd;
    } rel_rect_t;

    // First member lands in the top bits: x ends up lowest
    typedef struct packed {
        size_t  width;
        size_t  height;
        coord_t y;
        coord_t x;
    } out_rect_t;

    function automatic rel_rect_t mk_rect(input rel_t dx, input rel_t dy,
                                          input rel_t h, input rel_t wd);
        rel_rect_t r;
        r.dx = dx;
        r.dy = dy;
        r.h  = h;
        r.wd = wd;
        return r;
    endfunction

    function automatic coord_t sat_coord(input coord_t base, input rel_t off);
        logic signed [SUM_BITS-1:0] s;
        s = SUM_BITS'(base) + SUM_BITS'(off);
        if (s < COORD_LO)
            s = COORD_LO;
        else if (s > COORD_HI)
            s = COORD_HI;
        return coord_t'(s);
    endfunction

    function automatic size_t sat_size(input rel_t v);
        size_t r;
        if (v < rel_t'(0))
            r = '0;
        else if (v > SIZE_LIMIT)
            r = '1;
        else
            r = size_t'(v);
        return r;
    endfunction

endpackage

>>> design/glyph_to_rectangle_decomposer.sv
// Top level of the glyph to rectangle decomposer: geometry, stroke table, emitter, output.
//
// Usage: each transfer on the s_* channel is a draw request (cell corner and glyph code).
// For every request the block sends the stroke rectangles of that glyph on the m_*
// channel, one transfer per rectangle, with m_tlast on the last one. Glyph codes that
// have no strokes produce no transfer at all.
// Font width, height and weight are set through cfg_wr_en / cfg_index / cfg_wdata while
// no request is in flight; a write at the same edge as a request already applies to it.
// Path: a request passes the geometry stage, stroke table stage, emitter stage and
// output register before its first rectangle appears on m_tdata.
// Throughput: one rectangle per cycle while m_tready is high; a glyph with k strokes
// (2 to 7) holds the emitter stage until all k are sent. Requests keep streaming into
// the first two stages while the emitter works.
// Reset: all stages empty, font registers at 16 x 28 with weight 4.
// When m_tready is low the output register and the emitter hold, and the stall backs
// up through the stages to s_tready; nothing is dropped or sent twice.
module glyph_to_rectangle_decomposer
    import gtrd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_DATA_BITS-1:0]  s_tdata,   // pos_x, pos_y, glyph
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_DATA_BITS-1:0]  m_tdata,   // rect_x, rect_y, rect_height, rect_width
    output logic                    m_tlast,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_wdata
);

    logic [CFG_BITS-1:0] font_width_reg;
    logic [CFG_BITS-1:0] font_height_reg;
    logic [CFG_BITS-1:0] font_weight_reg;

    logic      s1_valid_reg;
    coord_t    s1_x_reg;
    coord_t    s1_y_reg;
    glyph_t    s1_glyph_reg;
    geom_t     s1_geom_reg;
    geom_t     s1_geom_next;

    logic      s2_valid_reg;
    coord_t    s2_x_reg;
    coord_t    s2_y_reg;
    rect_idx_t s2_cnt_reg;
    rect_idx_t s2_cnt_next;
    rel_rect_t s2_rects_reg  [MAX_RECTS];
    rel_rect_t s2_rects_next [MAX_RECTS];

    logic      s3_valid_reg;
    rect_idx_t s3_idx_reg;
    rect_idx_t s3_last_reg;
    out_rect_t s3_rects_reg  [MAX_RECTS];
    out_rect_t s3_rects_next [MAX_RECTS];

    logic      m_tvalid_reg;
    logic      m_tlast_reg;
    out_rect_t m_rect_reg;

    logic out_ready;
    logic s3_fire;
    logic s3_done;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;
    logic s1_load;

    logic [CFG_BITS-1:0]              eff_w;
    logic [CFG_BITS-1:0]              eff_h;
    logic [CFG_BITS-1:0]              eff_wt;
    logic [CFG_BITS+RECIP7_BITS-1:0]  m7;
    logic [CFG_BITS+RECIP10_BITS-1:0] m10;
    logic [CFG_BITS+RECIPN_BITS-1:0]  mn;
    rel_t                             vh;
    rel_t                             vw;
    rel_t                             w10;

    // ---------------- handshake chain ----------------
    assign out_ready = !m_tvalid_reg || m_tready;
    assign s3_fire   = s3_valid_reg && out_ready;
    assign s3_done   = s3_fire && (s3_idx_reg == s3_last_reg);
    assign s3_ready  = !s3_valid_reg || s3_done;
    // a glyph without strokes is dropped here and never waits for the emitter
    assign s2_ready  = !s2_valid_reg || (s2_cnt_reg == '0) || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s1_load   = s_tvalid && s1_ready;
    assign s_tready  = s1_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_width_reg  <= FONT_WIDTH_RST;
            font_height_reg <= FONT_HEIGHT_RST;
            font_weight_reg <= FONT_WEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_FONT_WIDTH)
                font_width_reg <= cfg_wdata;
            if (cfg_index == REG_FONT_HEIGHT)
                font_height_reg <= cfg_wdata;
            if (cfg_index == REG_FONT_WEIGHT)
                font_weight_reg <= cfg_wdata;
        end
    end

    // bypass a write made at the same edge as the request
    assign eff_w  = (cfg_wr_en && cfg_index == REG_FONT_WIDTH)  ? cfg_wdata : font_width_reg;
    assign eff_h  = (cfg_wr_en && cfg_index == REG_FONT_HEIGHT) ? cfg_wdata : font_height_reg;
    assign eff_wt = (cfg_wr_en && cfg_index == REG_FONT_WEIGHT) ? cfg_wdata : font_weight_reg;

    // ---------------- stage 1: cell geometry ----------------
    assign m7  = (CFG_BITS+RECIP7_BITS)'(eff_wt) * (CFG_BITS+RECIP7_BITS)'(RECIP7);
    assign m10 = (CFG_BITS+RECIP10_BITS)'(eff_wt) * (CFG_BITS+RECIP10_BITS)'(RECIP10);
    assign mn  = (CFG_BITS+RECIPN_BITS)'(eff_wt) * (CFG_BITS+RECIPN_BITS)'(RECIPN);
    assign vh  = rel_t'(eff_h) - rel_t'(eff_wt);
    assign vw  = rel_t'(eff_w) - rel_t'(eff_wt);
    assign w10 = rel_t'(m10 >> SHIFT10);

    always_comb
    begin
        s1_geom_next.fw   = rel_t'(eff_w);
        s1_geom_next.fh   = rel_t'(eff_h);
        s1_geom_next.wt   = rel_t'(eff_wt);
        s1_geom_next.h2   = rel_t'(eff_h >> 1);
        s1_geom_next.w2   = rel_t'(eff_wt >> 1);
        s1_geom_next.w7   = rel_t'(m7 >> SHIFT7);
        s1_geom_next.d    = rel_t'(eff_wt >> 1) + w10;
        s1_geom_next.n    = rel_t'(mn >> SHIFTN);
        // halve and quarter with truncation toward zero for negative values
        s1_geom_next.bar  = (vh + rel_t'(vh[REL_BITS-1])) >>> 1;
        s1_geom_next.qr   = (vh + (vh[REL_BITS-1] ? rel_t'(3) : rel_t'(0))) >>> 2;
        s1_geom_next.tx   = (vw + rel_t'(vw[REL_BITS-1])) >>> 1;
        s1_geom_next.w15a = (rel_t'(eff_wt) * rel_t'(3) + rel_t'(1)) >>> 1;
        s1_geom_next.w15b = ((rel_t'(eff_wt) * rel_t'(3)) >>> 1) + rel_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_x_reg     <= coord_t'(s_tdata[COORD_BITS-1:0]);
            s1_y_reg     <= coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
            s1_glyph_reg <= s_tdata[2*COORD_BITS+GLYPH_BITS-1:2*COORD_BITS];
            s1_geom_reg  <= s1_geom_next;
        end
    end

    // ---------------- stage 2: stroke table ----------------
    always_comb
    begin
        rel_t fw;
        rel_t fh;
        rel_t wt;
        rel_t h2;
        rel_t w2;
        rel_t w7;
        rel_t mid;
        rel_t low;
        rel_t q;
        rel_t wmw;
        rel_t hmw;
        rel_t hm2w;
        fw   = s1_geom_reg.fw;
        fh   = s1_geom_reg.fh;
        wt   = s1_geom_reg.wt;
        h2   = s1_geom_reg.h2;
        w2   = s1_geom_reg.w2;
        w7   = s1_geom_reg.w7;
        mid  = h2 - w2;
        low  = h2 + w2;
        q    = h2 - wt - w2;
        wmw  = fw - wt;
        hmw  = fh - wt;
        hm2w = fh - wt - wt;
        for (int i = 0; i < MAX_RECTS; i++)
            s2_rects_next[i] = '0;
        s2_cnt_next = '0;
        unique case (s1_glyph_reg)
            GLYPH_D0, GLYPH_O:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, wt, hm2w, wt);
                s2_rects_next[2] = mk_rect(wmw, wt, hm2w, wt);
                s2_rects_next[3] = mk_rect('0, hmw, wt, fw);
                s2_cnt_next      = rect_idx_t'(4);
            end
            GLYPH_D1:
            begin
                s2_rects_next[0] = mk_rect(fw - s1_geom_reg.w15a, '0, wt, s1_geom_reg.w15b);
                s2_rects_next[1] = mk_rect(wmw, wt, hmw, wt);
                s2_cnt_next      = rect_idx_t'(2);
            end
            GLYPH_D2:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, mid, wt, fw);
                s2_rects_next[2] = mk_rect('0, hmw, wt, fw);
                s2_rects_next[3] = mk_rect('0, low, q, wt);
                s2_rects_next[4] = mk_rect(wmw, wt, q, wt);
                s2_cnt_next      = rect_idx_t'(5);
            end
            GLYPH_D3:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect(w2, mid, wt, fw - w2);
                s2_rects_next[2] = mk_rect('0, hmw, wt, fw);
                s2_rects_next[3] = mk_rect(wmw, low, q, wt);
                s2_rects_next[4] = mk_rect(wmw, wt, q, wt);
                s2_cnt_next      = rect_idx_t'(5);
            end
            GLYPH_D4:
            begin
                s2_rects_next[0] = mk_rect(wmw, '0, fh, wt);
                s2_rects_next[1] = mk_rect('0, '0, mid, wt);
                s2_rects_next[2] = mk_rect('0, mid, wt, wmw);
                s2_cnt_next      = rect_idx_t'(3);
            end
            GLYPH_D5, GLYPH_S:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, mid, wt, fw);
                s2_rects_next[2] = mk_rect('0, hmw, wt, fw);
                s2_rects_next[3] = mk_rect(wmw, low, q, wt);
                s2_rects_next[4] = mk_rect('0, wt, q, wt);
                s2_cnt_next      = rect_idx_t'(5);
            end
            GLYPH_D6:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, mid, wt, fw);
                s2_rects_next[2] = mk_rect('0, hmw, wt, fw);
                s2_rects_next[3] = mk_rect(wmw + w7, low, q, wt - w7);
                s2_rects_next[4] = mk_rect('0, wt, q, wt);
                s2_rects_next[5] = mk_rect('0, low, q, wt);
                s2_cnt_next      = rect_idx_t'(6);
            end
            GLYPH_D8:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, mid, wt, fw);
                s2_rects_next[2] = mk_rect('0, hmw, wt, fw);
                s2_rects_next[3] = mk_rect(wmw + w7, low, q, wt - w7);
                s2_rects_next[4] = mk_rect('0, wt, q, wt);
                s2_rects_next[5] = mk_rect('0, low, q, wt);
                s2_rects_next[6] = mk_rect(wmw, wt, q, wt);
                s2_cnt_next      = rect_idx_t'(7);
            end
            GLYPH_D9:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, mid, wt, fw);
                s2_rects_next[2] = mk_rect('0, hmw, wt, fw);
                s2_rects_next[3] = mk_rect(wmw + w7, low, q, wt - w7);
                s2_rects_next[4] = mk_rect('0, wt, q, wt - w7);
                s2_rects_next[5] = mk_rect(wmw, wt, q, wt);
                s2_cnt_next      = rect_idx_t'(6);
            end
            GLYPH_D7:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect(wmw, wt, h2 - wt, wt);
                s2_rects_next[2] = mk_rect(wmw, h2, h2, wt);
                s2_cnt_next      = rect_idx_t'(3);
            end
            GLYPH_A:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, wt, hmw, wt);
                s2_rects_next[2] = mk_rect(wt, s1_geom_reg.bar, wt, wmw);
                s2_rects_next[3] = mk_rect(wmw, wt, hmw, wt);
                s2_cnt_next      = rect_idx_t'(4);
            end
            GLYPH_F:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, wt, hmw, wt);
                s2_rects_next[2] = mk_rect(wt, s1_geom_reg.bar, wt, wmw);
                s2_cnt_next      = rect_idx_t'(3);
            end
            GLYPH_P:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, wt, hmw, wt);
                s2_rects_next[2] = mk_rect(wt, s1_geom_reg.bar, wt, wmw);
                s2_rects_next[3] = mk_rect(wmw, wt, q, wt);
                s2_cnt_next      = rect_idx_t'(4);
            end
            GLYPH_R:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, wt, hmw, wt);
                s2_rects_next[2] = mk_rect(wt, s1_geom_reg.bar, wt, wmw);
                s2_rects_next[3] = mk_rect(wmw, wt, q, wt);
                s2_rects_next[4] = mk_rect(wmw - wt, low, s1_geom_reg.qr, wt);
                s2_rects_next[5] = mk_rect(wmw, low + s1_geom_reg.qr, s1_geom_reg.qr, wt);
                s2_cnt_next      = rect_idx_t'(6);
            end
            GLYPH_G:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect('0, wt, hm2w, wt);
                s2_rects_next[2] = mk_rect(wmw, h2, h2 - wt, wt);
                s2_rects_next[3] = mk_rect('0, hmw, wt, fw);
                s2_cnt_next      = rect_idx_t'(4);
            end
            GLYPH_N:
            begin
                s2_rects_next[0] = mk_rect('0, '0, fh, s1_geom_reg.n);
                s2_rects_next[1] = mk_rect(fw - s1_geom_reg.n, '0, fh, s1_geom_reg.n);
                s2_rects_next[2] = mk_rect(s1_geom_reg.n, '0, h2, s1_geom_reg.d);
                s2_rects_next[3] = mk_rect(fw - s1_geom_reg.n - s1_geom_reg.d, h2, h2,
                                           s1_geom_reg.d);
                s2_cnt_next      = rect_idx_t'(4);
            end
            GLYPH_T:
            begin
                s2_rects_next[0] = mk_rect('0, '0, wt, fw);
                s2_rects_next[1] = mk_rect(s1_geom_reg.tx, wt, hmw, wt);
                s2_cnt_next      = rect_idx_t'(2);
            end
            default:
            begin
                s2_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_x_reg   <= s1_x_reg;
            s2_y_reg   <= s1_y_reg;
            s2_cnt_reg <= s2_cnt_next;
            for (int i = 0; i < MAX_RECTS; i++)
                s2_rects_reg[i] <= s2_rects_next[i];
        end
    end

    // ---------------- stage 3: place, clamp and emit ----------------
    always_comb
    begin
        for (int i = 0; i < MAX_RECTS; i++)
        begin
            s3_rects_next[i].x      = sat_coord(s2_x_reg, s2_rects_reg[i].dx);
            s3_rects_next[i].y      = sat_coord(s2_y_reg, s2_rects_reg[i].dy);
            s3_rects_next[i].height = sat_size(s2_rects_reg[i].h);
            s3_rects_next[i].width  = sat_size(s2_rects_reg[i].wd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s3_idx_reg   <= '0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg && (s2_cnt_reg != '0);
            s3_idx_reg   <= '0;
        end
        else if (s3_fire)
        begin
            s3_idx_reg <= s3_idx_reg + rect_idx_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg && (s2_cnt_reg != '0))
        begin
            s3_last_reg <= s2_cnt_reg - rect_idx_t'(1);
            for (int i = 0; i < MAX_RECTS; i++)
                s3_rects_reg[i] <= s3_rects_next[i];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_ready)
            m_tvalid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_fire)
        begin
            m_rect_reg  <= s3_rects_reg[s3_idx_reg];
            m_tlast_reg <= (s3_idx_reg == s3_last_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = M_DATA_BITS'(m_rect_reg);

    // ---------------- assertions ----------------
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_idx_reg <= s3_last_reg))
        else $error("emitter index past last stroke");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        s3_done |=> (m_tvalid_reg && m_tlast_reg))
        else $error("final stroke not marked last");

    a_mid_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_fire && !s3_done) |=> (m_tvalid_reg && !m_tlast_reg))
        else $error("inner stroke marked last");

    a_emitter_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !out_ready) |=> (s3_valid_reg && $stable(s3_idx_reg)))
        else $error("emitter moved during output stall");

endmodule

>>> sim/glyph_to_rectangle_decomposer_tb.sv
// Testbench for the glyph to rectangle decomposer: directed table, random phases, self-check.
`timescale 1ns / 100ps

module glyph_to_rectangle_decomposer_tb
    import gtrd_pkg::*;
();

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int DIRECTED_ROWS    = 24;
    localparam int RANDOM_PHASES    = 10;
    localparam int ITEMS_PER_PHASE  = 35;
    localparam int SWAP_IDLE_PHASE  = 3;
    localparam int NO_IDLE_PHASE    = 7;
    localparam int HOLD_PHASE       = 8;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 12;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        coord_t x;
        coord_t y;
        size_t  h;
        size_t  wd;
        logic   last;
    } stroke_rect_t;

    typedef struct packed {
        coord_t       px;
        coord_t       py;
        glyph_t       g;
        logic         typed;
        logic [1:0]   n;
        stroke_rect_t r0;
        stroke_rect_t r1;
    } request_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_DATA_BITS-1:0]  s_tdata;   // pos_x, pos_y, glyph
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_DATA_BITS-1:0]  m_tdata;   // rect_x, rect_y, rect_height, rect_width
    logic                    m_tlast;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_wdata;

    // Shadow copy of the font registers
    logic [CFG_BITS-1:0] cell_w = FONT_WIDTH_RST;
    logic [CFG_BITS-1:0] cell_h = FONT_HEIGHT_RST;
    logic [CFG_BITS-1:0] stroke_w = FONT_WEIGHT_RST;

    stroke_rect_t pending_rects[$];
    stroke_rect_t glyph_strokes[MAX_RECTS];
    int           stroke_cnt;
    coord_t       origin_x;
    coord_t       origin_y;

    int send_idle_pct;
    int recv_idle_pct;
    bit long_hold_req;
    int error_count;

    request_row_t directed_rows [DIRECTED_ROWS] = '{
        '{12'sd0, 12'sd0, GLYPH_D1, 1'b1, 2'd2,
          '{12'sd10, 12'sd0, 9'd4, 9'd7, 1'b0}, '{12'sd12, 12'sd4, 9'd24, 9'd4, 1'b1}},
        '{-12'sd2048, -12'sd2048, GLYPH_D1, 1'b1, 2'd2,
          '{-12'sd2038, -12'sd2048, 9'd4, 9'd7, 1'b0},
          '{-12'sd2036, -12'sd2044, 9'd24, 9'd4, 1'b1}},
        '{12'sd2047, 12'sd2047, GLYPH_T, 1'b1, 2'd2,
          '{12'sd2047, 12'sd2047, 9'd4, 9'd16, 1'b0},
          '{12'sd2047, 12'sd2047, 9'd24, 9'd4, 1'b1}},
        '{12'sd0, 12'sd0, GLYPH_T, 1'b1, 2'd2,
          '{12'sd0, 12'sd0, 9'd4, 9'd16, 1'b0}, '{12'sd6, 12'sd4, 9'd24, 9'd4, 1'b1}},
        '{12'sd100, 12'sd50, 5'd31, 1'b1, 2'd0, '0, '0},
        '{-12'sd5, 12'sd7, 5'd19, 1'b1, 2'd0, '0, '0},
        '{12'sd10, 12'sd20, GLYPH_D0, 1'b0, 2'd0, '0, '0},
        '{12'sd30, -12'sd40, GLYPH_D2, 1'b0, 2'd0, '0, '0},
        '{-12'sd300, 12'sd200, GLYPH_D3, 1'b0, 2'd0, '0, '0},
        '{12'sd500, 12'sd500, GLYPH_D4, 1'b0, 2'd0, '0, '0},
        '{12'sd2040, 12'sd2030, GLYPH_D5, 1'b0, 2'd0, '0, '0},
        '{-12'sd2048, 12'sd0, GLYPH_D6, 1'b0, 2'd0, '0, '0},
        '{12'sd0, -12'sd2048, GLYPH_D7, 1'b0, 2'd0, '0, '0},
        '{12'sd2047, -12'sd2048, GLYPH_D8, 1'b0, 2'd0, '0, '0},
        '{12'sd123, 12'sd456, GLYPH_D9, 1'b0, 2'd0, '0, '0},
        '{-12'sd1, -12'sd1, GLYPH_A, 1'b0, 2'd0, '0, '0},
        '{12'sd64, 12'sd64, GLYPH_F, 1'b0, 2'd0, '0, '0},
        '{12'sd2035, 12'sd2035, GLYPH_G, 1'b0, 2'd0, '0, '0},
        '{-12'sd2040, 12'sd2040, GLYPH_N, 1'b0, 2'd0, '0, '0},
        '{12'sd77, -12'sd77, GLYPH_O, 1'b0, 2'd0, '0, '0},
        '{12'sd1000, -12'sd1000, GLYPH_P, 1'b0, 2'd0, '0, '0},
        '{-12'sd2048, 12'sd2047, GLYPH_R, 1'b0, 2'd0, '0, '0},
        '{12'sd2047, 12'sd0, GLYPH_S, 1'b0, 2'd0, '0, '0},
        '{-12'sd2046, -12'sd2046, GLYPH_D8, 1'b0, 2'd0, '0, '0}
    };

    glyph_to_rectangle_decomposer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic coord_t clamp_coord(input int v);
        int top;
        top = (1 << (COORD_BITS - 1)) - 1;
        if (v > top)
            return coord_t'(top);
        if (v < -top - 1)
            return coord_t'(-top - 1);
        return coord_t'(v);
    endfunction

    function automatic size_t clamp_size(input int v);
        if (v < 0)
            return '0;
        if (v > (1 << SIZE_BITS) - 1)
            return '1;
        return size_t'(v);
    endfunction

    function automatic void add_stroke(input int dx, input int dy, input int h, input int wd);
        stroke_rect_t r;
        r.x    = clamp_coord(int'(origin_x) + dx);
        r.y    = clamp_coord(int'(origin_y) + dy);
        r.h    = clamp_size(h);
        r.wd   = clamp_size(wd);
        r.last = 1'b0;
        glyph_strokes[stroke_cnt] = r;
        stroke_cnt++;
    endfunction

    // Work out the stroke rectangles of one draw request and queue them
    function automatic void decompose_glyph(input coord_t px, input coord_t py, input glyph_t g);
        int fw, fh, w, h2, w2, w7, mid, low, q, bar, qr, n, d, i;
        stroke_rect_t r;
        fw  = int'(cell_w);
        fh  = int'(cell_h);
        w   = int'(stroke_w);
        h2  = fh / 2;
        w2  = w / 2;
        w7  = w / 7;
        mid = h2 - w2;
        low = h2 + w2;
        q   = h2 - w - w2;
        bar = (fh - w) / 2;
        qr  = (fh - w) / 4;
        n   = (w * 4) / 5;
        d   = w2 + w / 10;
        origin_x   = px;
        origin_y   = py;
        stroke_cnt = 0;
        case (g)
            GLYPH_D0, GLYPH_O:
            begin
                add_stroke(0, 0, w, fw);
                add_stroke(0, w, fh - 2 * w, w);
                add_stroke(fw - w, w, fh - 2 * w, w);
                add_stroke(0, fh - w, w, fw);
            end
            GLYPH_D1:
            begin
                add_stroke(fw - ((3 * w + 1) >> 1), 0, w, ((3 * w) >> 1) + 1);
                add_stroke(fw - w, w, fh - w, w);
            end
            GLYPH_D2:
            begin
                add_stroke(0, 0, w, fw);
                add_stroke(0, mid, w, fw);
                add_stroke(0, fh - w, w, fw);
                add_stroke(0, low, q, w);
                add_stroke(fw - w, w, q, w);
            end
            GLYPH_D3:
            begin
                add_stroke(0, 0, w, fw);
                add_stroke(w2, mid, w, fw - w2);
                add_stroke(0, fh - w, w, fw);
                add_stroke(fw - w, low, q, w);
                add_stroke(fw - w, w, q, w);
            end
            GLYPH_D4:
            begin
                add_stroke(fw - w, 0, fh, w);
                add_stroke(0, 0, mid, w);
                add_stroke(0, mid, w, fw - w);
            end
            GLYPH_D5, GLYPH_S:
            begin
                add_stroke(0, 0, w, fw);
                add_stroke(0, mid, w, fw);
                add_stroke(0, fh - w, w, fw);
                add_stroke(fw - w, low, q, w);
                add_stroke(0, w, q, w);
            end
            GLYPH_D6, GLYPH_D8, GLYPH_D9:
            begin
                add_stroke(0, 0, w, fw);
                add_stroke(0, mid, w, fw);
                add_stroke(0, fh - w, w, fw);
                add_stroke(fw - w + w7, low, q, w - w7);
                add_stroke(0, w, q, (g == GLYPH_D9) ? w - w7 : w);
                if (g != GLYPH_D9)
                    add_stroke(0, low, q, w);
                if (g != GLYPH_D6)
                    add_stroke(fw - w, w, q, w);
            end
            GLYPH_D7:
            begin
                add_stroke(0, 0, w, fw);
                add_stroke(fw - w, w, h2 - w, w);
                add_stroke(fw - w, h2, h2, w);
            end
            GLYPH_A, GLYPH_F, GLYPH_P, GLYPH_R:
            begin
                add_stroke(0, 0, w, fw);
                add_stroke(0, w, fh - w, w);
                add_stroke(w, bar, w, fw - w);
                if (g == GLYPH_A)
                    add_stroke(fw - w, w, fh - w, w);
                if (g == GLYPH_P || g == GLYPH_R)
                    add_stroke(fw - w, w, q, w);
                if (g == GLYPH_R)
                begin
                    add_stroke(fw - 2 * w, w2 + h2, qr, w);
                    add_stroke(fw - w, w2 + h2 + qr, qr, w);
                end
            end
            GLYPH_G:
            begin
                add_stroke(0, 0, w, fw);
                add_stroke(0, w, fh - 2 * w, w);
                add_stroke(fw - w, h2, h2 - w, w);
                add_stroke(0, fh - w, w, fw);
            end
            GLYPH_N:
            begin
                add_stroke(0, 0, fh, n);
                add_stroke(fw - n, 0, fh, n);
                add_stroke(n, 0, h2, d);
                add_stroke(fw - n - d, h2, h2, d);
            end
            GLYPH_T:
            begin
                add_stroke(0, 0, w, fw);
                add_stroke((fw - w) / 2, w, fh - w, w);
            end
            default:
            begin
            end
        endcase
        for (i = 0; i < stroke_cnt; i++)
        begin
            r = glyph_strokes[i];
            r.last = (i == stroke_cnt - 1);
            pending_rects.push_back(r);
        end
    endfunction

    function automatic coord_t random_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return coord_t'($urandom);
        if (sel < 80)
            return ($urandom_range(1) == 1) ? coord_t'(2047 - int'($urandom_range(300)))
                                            : coord_t'(-2048 + int'($urandom_range(300)));
        return coord_t'(int'($urandom_range(64)) - 32);
    endfunction

    function automatic glyph_t random_glyph();
        if ($urandom_range(99) < 85)
            return glyph_t'($urandom_range(18));
        return glyph_t'($urandom_range(31, 19));
    endfunction

    // Offer one request from a falling edge on; return at the edge that takes it
    task automatic push_request(input coord_t px, input coord_t py, input glyph_t g);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_BITS'({g, py, px});
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop offering, wait for every queued rectangle, then let blank glyphs clear
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_rects.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_FONT_WIDTH:  cell_w = val;
            REG_FONT_HEIGHT: cell_h = val;
            REG_FONT_WEIGHT: stroke_w = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic load_font(input logic [CFG_BITS-1:0] fw, input logic [CFG_BITS-1:0] fh,
                             input logic [CFG_BITS-1:0] wt, input bit poke_unused);
        write_reg(REG_FONT_WIDTH, fw);
        write_reg(REG_FONT_HEIGHT, fh);
        write_reg(REG_FONT_WEIGHT, wt);
        if (poke_unused)
            write_reg(REG_UNUSED, CFG_BITS'($urandom));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: random back-pressure, plus one long hold counted here
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every rectangle transfer against the oldest expectation
    always @(posedge clk)
    begin
        stroke_rect_t got;
        stroke_rect_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x    = m_tdata[COORD_BITS-1:0];
            got.y    = m_tdata[2*COORD_BITS-1:COORD_BITS];
            got.h    = m_tdata[2*COORD_BITS +: SIZE_BITS];
            got.wd   = m_tdata[2*COORD_BITS+SIZE_BITS +: SIZE_BITS];
            got.last = m_tlast;
            if (pending_rects.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected rectangle x=%0d y=%0d h=%0d w=%0d last=%0b",
                             got.x, got.y, got.h, got.wd, got.last);
            end
            else
            begin
                want = pending_rects.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.h !== want.h ||
                    got.wd !== want.wd || got.last !== want.last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $write("rect mismatch exp x=%0d y=%0d h=%0d w=%0d last=%0b, ",
                               want.x, want.y, want.h, want.wd, want.last);
                        $display("got x=%0d y=%0d h=%0d w=%0d last=%0b",
                                 got.x, got.y, got.h, got.wd, got.last);
                    end
                end
            end
        end
    end

    initial
    begin
        int           k;
        int           phase;
        request_row_t row;
        coord_t       px;
        coord_t       py;
        glyph_t       g;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        long_hold_req = 1'b0;
        error_count   = 0;
        send_idle_pct = 33;
        recv_idle_pct = 56;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table under the reset font
        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            row = directed_rows[k];
            push_request(row.px, row.py, row.g);
            if (row.typed)
            begin
                if (row.n > 0)
                    pending_rects.push_back(row.r0);
                if (row.n > 1)
                    pending_rects.push_back(row.r1);
            end
            else
                decompose_glyph(row.px, row.py, row.g);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            if (phase == SWAP_IDLE_PHASE)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 33;
            end
            if (phase == NO_IDLE_PHASE)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: load_font(8'd1, 8'd1, 8'd1, 1'b0);
                1: load_font(8'd255, 8'd255, 8'd255, 1'b0);
                2: load_font(8'd255, 8'd255, 8'd1, 1'b0);
                3: load_font(8'd1, 8'd255, 8'd255, 1'b0);
                4: load_font(8'd0, 8'd0, 8'd0, 1'b0);
                5: load_font(8'd255, 8'd1, 8'd128, 1'b0);
                6: load_font(CFG_BITS'($urandom_range(255, 1)), CFG_BITS'($urandom_range(255, 1)),
                             CFG_BITS'($urandom_range(255, 1)), 1'b1);
                default:
                    load_font(CFG_BITS'($urandom_range(255, 1)), CFG_BITS'($urandom_range(255, 1)),
                              CFG_BITS'($urandom_range(40, 1)), 1'b0);
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Block the output for a while so the pipeline backs up into the input
                if (phase == HOLD_PHASE && k == 4)
                    long_hold_req = 1'b1;
                px = random_coord();
                py = random_coord();
                g  = random_glyph();
                push_request(px, py, g);
                decompose_glyph(px, py, g);
            end
        end

        drain_results();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
